@@ design/vpu_pkg.sv @@
// ----------------------------------------------------------------------------
// vpu_pkg
// Shared constants and transaction types of the vertex projection unit.
// ----------------------------------------------------------------------------
package vpu_pkg;

    localparam int COEF_W            = 32;
    localparam int FRAC_W            = 16;
    localparam int NUM_COEF          = 32;
    localparam int CIDX_W            = $clog2(NUM_COEF);
    localparam int MAT_N             = 4;
    localparam int V_BASE            = 0;
    localparam int P_BASE            = 16;
    localparam int SCR_W             = 16;
    localparam int QUOT_BITS         = SCR_W - 1;
    localparam int W_MIN_Q           = 65;
    localparam int DEF_SCREEN_WIDTH  = 320;
    localparam int DEF_SCREEN_HEIGHT = 180;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROJECT = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [CIDX_W-1:0]        coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [COEF_W-1:0] world_x;
        logic signed [COEF_W-1:0] world_y;
        logic signed [COEF_W-1:0] world_z;
    } vtx_item_t;

    typedef struct packed {
        logic                    visible;
        logic signed [SCR_W-1:0] screen_x;
        logic signed [SCR_W-1:0] screen_y;
    } pix_item_t;

endpackage

@@ design/vpu_stream_if.sv @@
// ----------------------------------------------------------------------------
// vpu_stream_if
// Valid/ready stream channel carrying one transaction payload.
// ----------------------------------------------------------------------------
interface vpu_stream_if #(
    parameter type item_t = logic
) ();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/vertex_projection_unit.sv @@
// ----------------------------------------------------------------------------
// vertex_projection_unit
// Throughput: one transaction per cycle; the 23-stage pipeline moves one stage
// per cycle and each stage stalls only while the stage after it is full.
// Load transactions write the matrix store in order and produce no result.
// Reset clears the pipeline valid bits and sets all 32 coefficients to zero.
// ----------------------------------------------------------------------------
module vertex_projection_unit
    import vpu_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic         clk,
    input  logic         rst_n,
    vpu_stream_if.sink   vtx_in,
    vpu_stream_if.source pix_out
);

    localparam int DIM_MAX  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int DIM_W    = $clog2(DIM_MAX + 1);
    localparam int MAG_W    = COEF_W + DIM_W;
    localparam int DEN_W    = COEF_W;
    localparam int SHD_W    = DEN_W + QUOT_BITS;
    localparam int REM_W    = (MAG_W > SHD_W) ? MAG_W : SHD_W;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int NUM_CLIP = 3;

    localparam int ST_VMUL  = 1;
    localparam int ST_PMUL  = 3;
    localparam int ST_CLIP  = 4;
    localparam int ST_DIV0  = 6;
    localparam int ST_OUT   = ST_DIV0 + QUOT_BITS + 1;
    localparam int NUM_ST   = ST_OUT + 1;

    localparam logic signed [SCR_W-1:0] SCR_MAX = {1'b0, {(SCR_W-1){1'b1}}};
    localparam logic signed [SCR_W-1:0] SCR_MIN = {1'b1, {(SCR_W-1){1'b0}}};

    function automatic logic signed [COEF_W-1:0] row_sum(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b,
        input logic signed [PROD_W-1:0] c,
        input logic signed [PROD_W-1:0] d
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] sh;
        s  = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
        sh = s >>> FRAC_W;
        if (sh[SUM_W-1:COEF_W-1] == '0 || sh[SUM_W-1:COEF_W-1] == '1)
        begin
            row_sum = sh[COEF_W-1:0];
        end
        else if (sh[SUM_W-1])
        begin
            row_sum = {1'b1, {(COEF_W-1){1'b0}}};
        end
        else
        begin
            row_sum = {1'b0, {(COEF_W-1){1'b1}}};
        end
    endfunction

    // ---------------- flow control ----------------
    logic [NUM_ST-1:0] v_reg;
    logic [NUM_ST-1:0] en;

    assign en[NUM_ST-1] = !v_reg[NUM_ST-1] || pix_out.ready;
    for (genvar i = 0; i < NUM_ST - 1; i++)
    begin : g_en
        assign en[i] = !v_reg[i] || en[i+1];
    end

    assign vtx_in.ready = en[0];

    // ---------------- stage registers ----------------
    vtx_item_t                s0_item_reg;
    logic signed [COEF_W-1:0] coef_reg [NUM_COEF];

    logic signed [PROD_W-1:0] pv_next [MAT_N][MAT_N];
    logic signed [PROD_W-1:0] pv_reg  [MAT_N][MAT_N];
    logic                     s1_cmd_reg, s2_cmd_reg, s3_cmd_reg;
    logic [CIDX_W-1:0]        s1_idx_reg, s2_idx_reg;
    logic signed [COEF_W-1:0] s1_val_reg, s2_val_reg;

    logic signed [COEF_W-1:0] eye_reg [MAT_N];

    logic signed [PROD_W-1:0] pp_next [NUM_CLIP][MAT_N];
    logic signed [PROD_W-1:0] pp_reg  [NUM_CLIP][MAT_N];

    logic signed [COEF_W-1:0] clip_reg [NUM_CLIP];

    logic signed [COEF_W:0]   ax, ay;
    logic [COEF_W-1:0]        magx, magy;
    logic [MAG_W-1:0]         nx_reg, ny_reg;
    logic                     negx_reg, negy_reg, vis5_reg;
    logic [DEN_W-1:0]         den5_reg;

    logic [REM_W-1:0]         rx_reg   [QUOT_BITS+1];
    logic [REM_W-1:0]         ry_reg   [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]     qx_reg   [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]     qy_reg   [QUOT_BITS+1];
    logic [DEN_W-1:0]         dd_reg   [QUOT_BITS+1];
    logic                     dvis_reg [QUOT_BITS+1];
    logic                     dnx_reg  [QUOT_BITS+1];
    logic                     dny_reg  [QUOT_BITS+1];
    logic                     dox_reg  [QUOT_BITS+1];
    logic                     doy_reg  [QUOT_BITS+1];

    pix_item_t                pix_reg;
    logic signed [SCR_W-1:0]  sx_next, sy_next;

    // ---------------- valid bits and coefficient store ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= vtx_in.valid;
            end
            for (int i = 1; i < NUM_ST; i++)
            begin
                if (en[i])
                begin
                    // drop load transactions once the projection matrix stage is passed
                    v_reg[i] <= (i == ST_CLIP) ? (v_reg[i-1] && s3_cmd_reg == CMD_PROJECT)
                                               : v_reg[i-1];
                end
            end
        end
    end

    // Each matrix is written as a load leaves the stage that reads it, so a
    // projection always sees the loads that came before it and no later ones.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '{default: '0};
        end
        else
        begin
            if (v_reg[0] && en[ST_VMUL] && s0_item_reg.cmd == CMD_LOAD &&
                !s0_item_reg.coef_index[CIDX_W-1])
            begin
                coef_reg[s0_item_reg.coef_index] <= s0_item_reg.coef_value;
            end
            if (v_reg[ST_PMUL-1] && en[ST_PMUL] && s2_cmd_reg == CMD_LOAD &&
                s2_idx_reg[CIDX_W-1])
            begin
                coef_reg[s2_idx_reg] <= s2_val_reg;
            end
        end
    end

    // ---------------- stage 0: input register ----------------
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_item_reg <= vtx_in.data;
        end
    end

    // ---------------- stage 1: view matrix products ----------------
    always_comb
    begin
        for (int r = 0; r < MAT_N; r++)
        begin
            pv_next[r][0] = coef_reg[V_BASE + r] * s0_item_reg.world_x;
            pv_next[r][1] = coef_reg[V_BASE + r + MAT_N] * s0_item_reg.world_y;
            pv_next[r][2] = coef_reg[V_BASE + r + 2*MAT_N] * s0_item_reg.world_z;
            // w is 1.0, so the last column only shifts into place
            pv_next[r][3] = $signed({{(PROD_W-COEF_W-FRAC_W){coef_reg[V_BASE+r+3*MAT_N][COEF_W-1]}},
                                     coef_reg[V_BASE + r + 3*MAT_N], {FRAC_W{1'b0}}});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_VMUL])
        begin
            pv_reg     <= pv_next;
            s1_cmd_reg <= s0_item_reg.cmd;
            s1_idx_reg <= s0_item_reg.coef_index;
            s1_val_reg <= s0_item_reg.coef_value;
        end
    end

    // ---------------- stage 2: eye coordinates ----------------
    always_ff @(posedge clk)
    begin
        if (en[ST_PMUL-1])
        begin
            for (int r = 0; r < MAT_N; r++)
            begin
                eye_reg[r] <= row_sum(pv_reg[r][0], pv_reg[r][1], pv_reg[r][2], pv_reg[r][3]);
            end
            s2_cmd_reg <= s1_cmd_reg;
            s2_idx_reg <= s1_idx_reg;
            s2_val_reg <= s1_val_reg;
        end
    end

    // ---------------- stage 3: projection matrix products ----------------
    // clip z is never used: only rows x, y and w are formed
    always_comb
    begin
        for (int j = 0; j < NUM_CLIP; j++)
        begin
            for (int k = 0; k < MAT_N; k++)
            begin
                pp_next[j][k] = coef_reg[P_BASE + ((j == NUM_CLIP-1) ? MAT_N-1 : j) + MAT_N*k]
                                * eye_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PMUL])
        begin
            pp_reg     <= pp_next;
            s3_cmd_reg <= s2_cmd_reg;
        end
    end

    // ---------------- stage 4: clip coordinates ----------------
    always_ff @(posedge clk)
    begin
        if (en[ST_CLIP])
        begin
            for (int j = 0; j < NUM_CLIP; j++)
            begin
                clip_reg[j] <= row_sum(pp_reg[j][0], pp_reg[j][1], pp_reg[j][2], pp_reg[j][3]);
            end
        end
    end

    // ---------------- stage 5: viewport numerators ----------------
    always_comb
    begin
        ax   = {clip_reg[0][COEF_W-1], clip_reg[0]} + {clip_reg[2][COEF_W-1], clip_reg[2]};
        ay   = {clip_reg[2][COEF_W-1], clip_reg[2]} - {clip_reg[1][COEF_W-1], clip_reg[1]};
        magx = ax[COEF_W] ? COEF_W'(-ax) : ax[COEF_W-1:0];
        magy = ay[COEF_W] ? COEF_W'(-ay) : ay[COEF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_CLIP+1])
        begin
            nx_reg   <= MAG_W'(magx) * MAG_W'(SCREEN_WIDTH);
            ny_reg   <= MAG_W'(magy) * MAG_W'(SCREEN_HEIGHT);
            negx_reg <= ax[COEF_W];
            negy_reg <= ay[COEF_W];
            vis5_reg <= clip_reg[2] > $signed(COEF_W'(W_MIN_Q));
            den5_reg <= {clip_reg[2][COEF_W-2:0], 1'b0};
        end
    end

    // ---------------- stage 6: overflow check, divider setup ----------------
    always_ff @(posedge clk)
    begin
        if (en[ST_DIV0])
        begin
            rx_reg[0]   <= REM_W'(nx_reg);
            ry_reg[0]   <= REM_W'(ny_reg);
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            dd_reg[0]   <= den5_reg;
            dvis_reg[0] <= vis5_reg;
            dnx_reg[0]  <= negx_reg;
            dny_reg[0]  <= negy_reg;
            dox_reg[0]  <= REM_W'(nx_reg) >= (REM_W'(den5_reg) << QUOT_BITS);
            doy_reg[0]  <= REM_W'(ny_reg) >= (REM_W'(den5_reg) << QUOT_BITS);
        end
    end

    // ---------------- stages 7..21: restoring division, one bit each ----------------
    for (genvar d = 0; d < QUOT_BITS; d++)
    begin : g_div
        localparam int BIT = QUOT_BITS - 1 - d;
        logic [REM_W-1:0] shd;
        logic             hitx, hity;

        assign shd  = REM_W'(dd_reg[d]) << BIT;
        assign hitx = rx_reg[d] >= shd;
        assign hity = ry_reg[d] >= shd;

        always_ff @(posedge clk)
        begin
            if (en[ST_DIV0+1+d])
            begin
                rx_reg[d+1]   <= hitx ? rx_reg[d] - shd : rx_reg[d];
                ry_reg[d+1]   <= hity ? ry_reg[d] - shd : ry_reg[d];
                qx_reg[d+1]   <= qx_reg[d] | (QUOT_BITS'(hitx) << BIT);
                qy_reg[d+1]   <= qy_reg[d] | (QUOT_BITS'(hity) << BIT);
                dd_reg[d+1]   <= dd_reg[d];
                dvis_reg[d+1] <= dvis_reg[d];
                dnx_reg[d+1]  <= dnx_reg[d];
                dny_reg[d+1]  <= dny_reg[d];
                dox_reg[d+1]  <= dox_reg[d];
                doy_reg[d+1]  <= doy_reg[d];
            end
        end
    end

    // ---------------- stage 22: sign, saturation, output register ----------------
    always_comb
    begin
        if (dox_reg[QUOT_BITS])
        begin
            sx_next = dnx_reg[QUOT_BITS] ? SCR_MIN : SCR_MAX;
        end
        else
        begin
            sx_next = dnx_reg[QUOT_BITS] ? -{1'b0, qx_reg[QUOT_BITS]} : {1'b0, qx_reg[QUOT_BITS]};
        end
        if (doy_reg[QUOT_BITS])
        begin
            sy_next = dny_reg[QUOT_BITS] ? SCR_MIN : SCR_MAX;
        end
        else
        begin
            sy_next = dny_reg[QUOT_BITS] ? -{1'b0, qy_reg[QUOT_BITS]} : {1'b0, qy_reg[QUOT_BITS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            pix_reg.visible  <= dvis_reg[QUOT_BITS];
            pix_reg.screen_x <= dvis_reg[QUOT_BITS] ? sx_next : '0;
            pix_reg.screen_y <= dvis_reg[QUOT_BITS] ? sy_next : '0;
        end
    end

    assign pix_out.valid = v_reg[ST_OUT];
    assign pix_out.data  = pix_reg;

endmodule

@@ design/vpu_checker.sv @@
// ----------------------------------------------------------------------------
// vpu_checker
// Port-level checks on the vertex projection unit, attached by bind.
// ----------------------------------------------------------------------------
module vpu_checker
    import vpu_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input pix_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result payload changed while stalled");

    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.visible |-> out_data.screen_x == '0 && out_data.screen_y == '0)
        else $error("hidden point carries nonzero coordinates");

    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output side is ready");

endmodule

bind vertex_projection_unit vpu_checker u_vpu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (vtx_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_data  (pix_out.data)
);
